@@ rtl/ssfs_pkg.sv @@
`timescale 1ns / 1ps
// ssfs_pkg: field widths and stream word layout for the sprite sheet frame slicer
// no dependencies

package ssfs_pkg;

   // request word fields
   localparam int TEX_FIELD_W  = 13;
   localparam int ORG_FIELD_W  = 12;
   localparam int TILE_FIELD_W = 13;
   localparam int PAD_FIELD_W  = 12;
   localparam int WANT_FIELD_W = 7;

   // result word fields
   localparam int IDX_FIELD_W  = 6;
   localparam int RECT_XY_W    = 12;
   localparam int RECT_WH_W    = 13;

   // step width: tile size plus padding
   localparam int STEP_W       = 14;

   localparam int REQ_DATA_W   = 112;
   localparam int RSP_DATA_W   = 64;

endpackage

@@ rtl/ssfs_step_unit.sv @@
`timescale 1ns / 1ps
// ssfs_step_unit: shared position unit, range test, edge clipping and step advance
// depends on ssfs_pkg

module ssfs_step_unit import ssfs_pkg::*; #(
   parameter int POS_W = 15
) (
   input  logic [POS_W-1:0]        pos,
   input  logic [POS_W-1:0]        lim,
   input  logic [TILE_FIELD_W-1:0] size,
   input  logic [STEP_W-1:0]       step,
   output logic                    in_range,
   output logic [RECT_WH_W-1:0]    clip,
   output logic [POS_W-1:0]        next
);

   logic [POS_W:0] far_edge;
   logic [POS_W:0] remain;

   always_comb begin
      far_edge = {1'b0, pos} + (POS_W+1)'(size);
      remain   = {1'b0, lim} - {1'b0, pos};
      in_range = pos < lim;
      // clipped size never exceeds the nominal size, so it fits the field
      if (far_edge > {1'b0, lim}) begin
         clip = remain[RECT_WH_W-1:0];
      end else begin
         clip = size;
      end
      next = pos + POS_W'(step);
   end

endmodule

@@ rtl/sprite_sheet_frame_slicer.sv @@
`timescale 1ns / 1ps
// sprite_sheet_frame_slicer: top level, request decode, walk sequencer and result register
// depends on ssfs_pkg and ssfs_step_unit

// One request word describes a texture and a tile grid; the block walks tile
// positions row by row from origin plus padding and returns one result word
// per frame rectangle, clipped at the right and bottom texture edges, up to
// frames_wanted (saturated to MAX_FRAMES). Rows after the first restart at
// origin_x + pad_x in subregion mode, otherwise at pad_x. The last word of a
// request carries tlast and, in short_count, whether fewer frames were found
// than asked for. With no tile, zero frames wanted or a zero step, exactly one
// word with frame_valid low is returned. A single position unit is shared by
// a small sequencer: a row step per row visited (range test, height clip and
// next row), a column step per column position tested, including the one
// past the right edge that ends a row, and a send step for each frame word
// after the first, since each frame word is held one step so that tlast can
// be set on the true last one. Send steps wait on output back-pressure; the
// block takes the next request once the last word of the previous one has
// been taken.

module sprite_sheet_frame_slicer import ssfs_pkg::*; #(
   parameter int MAX_FRAMES   = 64,
   parameter int MAX_TEX_SIZE = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: tex_width, tex_height, origin_x, origin_y, tile_w, tile_h,
   //          pad_x, pad_y, frames_wanted, subregion_mode, zero fill
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // result: frame_index, rect_x, rect_y, rect_w, rect_h, short_count, zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // result tuser: frame_valid
   output logic                  rsp_tuser
);

   localparam int TEX_W = $clog2(MAX_TEX_SIZE + 1);
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int POS_W = ((TEX_W > TEX_FIELD_W) ? TEX_W : TEX_FIELD_W) + 2;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ROW    = 3'd1;
   localparam logic [2:0] S_COL    = 3'd2;
   localparam logic [2:0] S_SEND   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;
   localparam logic [2:0] S_END    = 3'd5;

   // request word unpacking
   logic [TEX_FIELD_W-1:0]  in_tex_w, in_tex_h;
   logic [ORG_FIELD_W-1:0]  in_org_x, in_org_y;
   logic [TILE_FIELD_W-1:0] in_tile_w, in_tile_h;
   logic [PAD_FIELD_W-1:0]  in_pad_x, in_pad_y;
   logic [WANT_FIELD_W-1:0] in_want;
   logic                    in_sub;

   assign in_tex_w  = req_tdata[12:0];
   assign in_tex_h  = req_tdata[25:13];
   assign in_org_x  = req_tdata[37:26];
   assign in_org_y  = req_tdata[49:38];
   assign in_tile_w = req_tdata[62:50];
   assign in_tile_h = req_tdata[75:63];
   assign in_pad_x  = req_tdata[87:76];
   assign in_pad_y  = req_tdata[99:88];
   assign in_want   = req_tdata[106:100];
   assign in_sub    = req_tdata[107];

   // sequencer and walk state
   logic [2:0]              state_ff, state_in;
   logic [TEX_W-1:0]        tw_ff, tw_in, th_ff, th_in;
   logic [TILE_FIELD_W-1:0] cw_ff, cw_in, ch_ff, ch_in;
   logic [STEP_W-1:0]       sx_ff, sx_in, sy_ff, sy_in;
   logic [POS_W-1:0]        restart_ff, restart_in;
   logic [POS_W-1:0]        col_ff, col_in, row_ff, row_in, row_next_ff, row_next_in;
   logic [RECT_WH_W-1:0]    row_h_ff, row_h_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in, want_ff, want_in;

   // held frame, sent once the next one is found or the walk ends
   logic                    held_ff, held_in;
   logic [IDX_FIELD_W-1:0]  h_idx_ff, h_idx_in;
   logic [RECT_XY_W-1:0]    h_x_ff, h_x_in, h_y_ff, h_y_in;
   logic [RECT_WH_W-1:0]    h_w_ff, h_w_in, h_h_ff, h_h_in;

   // result register
   logic                    o_valid_ff, o_valid_in;
   logic                    o_fv_ff, o_fv_in, o_last_ff, o_last_in, o_short_ff, o_short_in;
   logic [IDX_FIELD_W-1:0]  o_idx_ff, o_idx_in;
   logic [RECT_XY_W-1:0]    o_x_ff, o_x_in, o_y_ff, o_y_in;
   logic [RECT_WH_W-1:0]    o_w_ff, o_w_in, o_h_ff, o_h_in;

   // shared unit
   logic [POS_W-1:0]        u_pos, u_lim, u_next;
   logic [TILE_FIELD_W-1:0] u_size;
   logic [STEP_W-1:0]       u_step;
   logic                    u_in_range;
   logic [RECT_WH_W-1:0]    u_clip;

   // row cycles test the vertical axis, column cycles the horizontal one
   always_comb begin
      if (state_ff == S_ROW) begin
         u_pos  = row_ff;
         u_lim  = POS_W'(th_ff);
         u_size = ch_ff;
         u_step = sy_ff;
      end else begin
         u_pos  = col_ff;
         u_lim  = POS_W'(tw_ff);
         u_size = cw_ff;
         u_step = sx_ff;
      end
   end

   ssfs_step_unit #(
      .POS_W (POS_W)
   ) u_step_unit (
      .pos      (u_pos),
      .lim      (u_lim),
      .size     (u_size),
      .step     (u_step),
      .in_range (u_in_range),
      .clip     (u_clip),
      .next     (u_next)
   );

   logic rsp_take;
   logic step_zero;

   assign rsp_take   = o_valid_ff && rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      tw_in       = tw_ff;
      th_in       = th_ff;
      cw_in       = cw_ff;
      ch_in       = ch_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      restart_in  = restart_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      row_next_in = row_next_ff;
      row_h_in    = row_h_ff;
      cnt_in      = cnt_ff;
      want_in     = want_ff;
      held_in     = held_ff;
      h_idx_in    = h_idx_ff;
      h_x_in      = h_x_ff;
      h_y_in      = h_y_ff;
      h_w_in      = h_w_ff;
      h_h_in      = h_h_ff;
      o_valid_in  = o_valid_ff;
      o_fv_in     = o_fv_ff;
      o_last_in   = o_last_ff;
      o_short_in  = o_short_ff;
      o_idx_in    = o_idx_ff;
      o_x_in      = o_x_ff;
      o_y_in      = o_y_ff;
      o_w_in      = o_w_ff;
      o_h_in      = o_h_ff;
      step_zero   = 1'b0;

      if (rsp_take) begin
         o_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               // saturate texture size and frame count
               if (32'(in_tex_w) > MAX_TEX_SIZE) begin
                  tw_in = TEX_W'(MAX_TEX_SIZE);
               end else begin
                  tw_in = TEX_W'(in_tex_w);
               end
               if (32'(in_tex_h) > MAX_TEX_SIZE) begin
                  th_in = TEX_W'(MAX_TEX_SIZE);
               end else begin
                  th_in = TEX_W'(in_tex_h);
               end
               if (32'(in_want) > MAX_FRAMES) begin
                  want_in = CNT_W'(MAX_FRAMES);
               end else begin
                  want_in = CNT_W'(in_want);
               end
               cw_in     = in_tile_w;
               ch_in     = in_tile_h;
               sx_in     = STEP_W'(in_tile_w) + STEP_W'(in_pad_x);
               sy_in     = STEP_W'(in_tile_h) + STEP_W'(in_pad_y);
               col_in    = POS_W'(in_org_x) + POS_W'(in_pad_x);
               row_in    = POS_W'(in_org_y) + POS_W'(in_pad_y);
               if (in_sub) begin
                  restart_in = POS_W'(in_org_x) + POS_W'(in_pad_x);
               end else begin
                  restart_in = POS_W'(in_pad_x);
               end
               cnt_in    = '0;
               held_in   = 1'b0;
               step_zero = (sx_in == '0) || (sy_in == '0);
               if (want_in == '0 || step_zero) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_ROW;
               end
            end
         end
         S_ROW: begin
            if (!u_in_range || cnt_ff == want_ff) begin
               state_in = S_FINISH;
            end else begin
               row_h_in    = u_clip;
               row_next_in = u_next;
               state_in    = S_COL;
            end
         end
         S_COL: begin
            if (cnt_ff == want_ff) begin
               state_in = S_FINISH;
            end else if (u_in_range) begin
               // tile found: the previously held one is not the last
               if (held_ff) begin
                  o_valid_in = 1'b1;
                  o_fv_in    = 1'b1;
                  o_last_in  = 1'b0;
                  o_short_in = 1'b0;
                  o_idx_in   = h_idx_ff;
                  o_x_in     = h_x_ff;
                  o_y_in     = h_y_ff;
                  o_w_in     = h_w_ff;
                  o_h_in     = h_h_ff;
                  state_in   = S_SEND;
               end
               held_in  = 1'b1;
               h_idx_in = IDX_FIELD_W'(cnt_ff);
               h_x_in   = col_ff[RECT_XY_W-1:0];
               h_y_in   = row_ff[RECT_XY_W-1:0];
               h_w_in   = u_clip;
               h_h_in   = row_h_ff;
               cnt_in   = cnt_ff + CNT_W'(1);
               col_in   = u_next;
            end else begin
               col_in   = restart_ff;
               row_in   = row_next_ff;
               state_in = S_ROW;
            end
         end
         S_SEND: begin
            if (rsp_take) begin
               state_in = S_COL;
            end
         end
         S_FINISH: begin
            o_valid_in = 1'b1;
            o_last_in  = 1'b1;
            if (held_ff) begin
               o_fv_in    = 1'b1;
               o_short_in = cnt_ff < want_ff;
               o_idx_in   = h_idx_ff;
               o_x_in     = h_x_ff;
               o_y_in     = h_y_ff;
               o_w_in     = h_w_ff;
               o_h_in     = h_h_ff;
            end else begin
               // no frame found
               o_fv_in    = 1'b0;
               o_short_in = want_ff != '0;
               o_idx_in   = '0;
               o_x_in     = '0;
               o_y_in     = '0;
               o_w_in     = '0;
               o_h_in     = '0;
            end
            state_in = S_END;
         end
         S_END: begin
            if (rsp_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         o_valid_ff <= 1'b0;
         held_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         o_valid_ff <= o_valid_in;
         held_ff    <= held_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      tw_ff       <= tw_in;
      th_ff       <= th_in;
      cw_ff       <= cw_in;
      ch_ff       <= ch_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      restart_ff  <= restart_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      row_next_ff <= row_next_in;
      row_h_ff    <= row_h_in;
      want_ff     <= want_in;
      h_idx_ff    <= h_idx_in;
      h_x_ff      <= h_x_in;
      h_y_ff      <= h_y_in;
      h_w_ff      <= h_w_in;
      h_h_ff      <= h_h_in;
      o_fv_ff     <= o_fv_in;
      o_last_ff   <= o_last_in;
      o_short_ff  <= o_short_in;
      o_idx_ff    <= o_idx_in;
      o_x_ff      <= o_x_in;
      o_y_ff      <= o_y_in;
      o_w_ff      <= o_w_in;
      o_h_ff      <= o_h_in;
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tuser  = o_fv_ff;
   assign rsp_tdata  = {7'd0, o_short_ff, o_h_ff, o_w_ff, o_y_ff, o_x_ff, o_idx_ff};

endmodule

@@ dv/tb_sprite_sheet_frame_slicer.sv @@
`timescale 1ns / 1ps
// tb_sprite_sheet_frame_slicer: self-checking bench for the sprite sheet frame slicer
// depends on ssfs_pkg and sprite_sheet_frame_slicer; stimulus, tile-walk prediction and checks

module tb_sprite_sheet_frame_slicer;
   import ssfs_pkg::*;

   localparam int FRAME_LIMIT = 64;
   localparam int TEX_LIMIT   = 4096;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int TAIL_CYCLES = 64;

   // one slicing request as the block sees it
   typedef struct {
      logic [TEX_FIELD_W-1:0]  tex_width;
      logic [TEX_FIELD_W-1:0]  tex_height;
      logic [ORG_FIELD_W-1:0]  origin_x;
      logic [ORG_FIELD_W-1:0]  origin_y;
      logic [TILE_FIELD_W-1:0] tile_w;
      logic [TILE_FIELD_W-1:0] tile_h;
      logic [PAD_FIELD_W-1:0]  pad_x;
      logic [PAD_FIELD_W-1:0]  pad_y;
      logic [WANT_FIELD_W-1:0] frames_wanted;
      logic                    subregion_mode;
   } sheet_request_type;

   // one frame rectangle word
   typedef struct {
      logic                   frame_valid;
      logic [IDX_FIELD_W-1:0] frame_index;
      logic [RECT_XY_W-1:0]   rect_x;
      logic [RECT_XY_W-1:0]   rect_y;
      logic [RECT_WH_W-1:0]   rect_w;
      logic [RECT_WH_W-1:0]   rect_h;
      logic                   last_frame;
      logic                   short_count;
   } frame_rect_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tex_width, tex_height, origin_x, origin_y, tile_w, tile_h, pad_x, pad_y,
   // frames_wanted, subregion_mode, zero fill
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // frame_index, rect_x, rect_y, rect_w, rect_h, short_count, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   // frame_valid
   logic                  rsp_tuser;

   frame_rect_type expected_frames[$];
   int          error_count   = 0;
   int          cycle_count   = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   // request valid left high for a back-to-back word
   bit          req_armed     = 1'b0;

   sprite_sheet_frame_slicer #(
      .MAX_FRAMES   (FRAME_LIMIT),
      .MAX_TEX_SIZE (TEX_LIMIT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // walk the tile grid row by row and queue the frame words one request yields
   function automatic void slice_sheet(input sheet_request_type r);
      int unsigned tex_w, tex_h, want, step_x, step_y, col, row, n;
      frame_rect_type f;
      frame_rect_type batch[$];
      tex_w  = (r.tex_width > TEX_LIMIT) ? TEX_LIMIT : r.tex_width;
      tex_h  = (r.tex_height > TEX_LIMIT) ? TEX_LIMIT : r.tex_height;
      want   = (r.frames_wanted > FRAME_LIMIT) ? FRAME_LIMIT : r.frames_wanted;
      step_x = r.tile_w + r.pad_x;
      step_y = r.tile_h + r.pad_y;
      n      = 0;
      if (want > 0 && step_x != 0 && step_y != 0) begin
         col = r.origin_x + r.pad_x;
         row = r.origin_y + r.pad_y;
         while (row < tex_h && n < want) begin
            while (col < tex_w && n < want) begin
               f.frame_valid = 1'b1;
               f.frame_index = n[IDX_FIELD_W-1:0];
               f.rect_x      = col[RECT_XY_W-1:0];
               f.rect_y      = row[RECT_XY_W-1:0];
               // clip at the right and bottom texture edges
               f.rect_w      = RECT_WH_W'((col + r.tile_w > tex_w) ? tex_w - col : r.tile_w);
               f.rect_h      = RECT_WH_W'((row + r.tile_h > tex_h) ? tex_h - row : r.tile_h);
               f.last_frame  = 1'b0;
               f.short_count = 1'b0;
               batch.push_back(f);
               n   += 1;
               col += step_x;
            end
            // next row restarts at origin plus padding in subregion mode
            col = r.subregion_mode ? r.origin_x + r.pad_x : r.pad_x;
            row += step_y;
         end
      end
      if (n == 0) begin
         // nothing found: one empty word
         f = '{default: '0};
         f.last_frame  = 1'b1;
         f.short_count = (want > 0);
         batch.push_back(f);
      end else begin
         batch[n-1].last_frame  = 1'b1;
         batch[n-1].short_count = (n < want);
      end
      foreach (batch[k]) expected_frames.push_back(batch[k]);
   endfunction

   function automatic sheet_request_type make_request(
      input int unsigned tex_w, tex_h, org_x, org_y, tl_w, tl_h, p_x, p_y, want,
      input bit sub);
      sheet_request_type r;
      r.tex_width      = TEX_FIELD_W'(tex_w);
      r.tex_height     = TEX_FIELD_W'(tex_h);
      r.origin_x       = ORG_FIELD_W'(org_x);
      r.origin_y       = ORG_FIELD_W'(org_y);
      r.tile_w         = TILE_FIELD_W'(tl_w);
      r.tile_h         = TILE_FIELD_W'(tl_h);
      r.pad_x          = PAD_FIELD_W'(p_x);
      r.pad_y          = PAD_FIELD_W'(p_y);
      r.frames_wanted  = WANT_FIELD_W'(want);
      r.subregion_mode = sub;
      return r;
   endfunction

   // present one request word, hold it until taken, then predict its frames
   task automatic send_request(input sheet_request_type r);
      if (!req_armed) begin
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tdata  <= {4'b0, r.subregion_mode, r.frames_wanted, r.pad_y, r.pad_x,
                     r.tile_h, r.tile_w, r.origin_y, r.origin_x,
                     r.tex_height, r.tex_width};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      slice_sheet(r);
      // decide now whether the next word follows back to back
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_armed  = 1'b0;
      end else begin
         req_armed = 1'b1;
      end
   endtask

   // stop offering words and let every expected frame come back
   task automatic wait_for_drain();
      if (req_armed) begin
         req_tvalid <= 1'b0;
         req_armed  = 1'b0;
      end
      while (expected_frames.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want_v, got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // compare every taken result word with the oldest prediction
   always @(posedge clock) begin : result_check
      frame_rect_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            $error("result word with no request outstanding");
            error_count++;
         end else begin
            w = expected_frames.pop_front();
            check_field("frame_valid", 32'(w.frame_valid), 32'(rsp_tuser));
            check_field("frame_index", 32'(w.frame_index), 32'(rsp_tdata[5:0]));
            check_field("rect_x",      32'(w.rect_x),      32'(rsp_tdata[17:6]));
            check_field("rect_y",      32'(w.rect_y),      32'(rsp_tdata[29:18]));
            check_field("rect_w",      32'(w.rect_w),      32'(rsp_tdata[42:30]));
            check_field("rect_h",      32'(w.rect_h),      32'(rsp_tdata[55:43]));
            check_field("last_frame",  32'(w.last_frame),  32'(rsp_tlast));
            check_field("short_count", 32'(w.short_count), 32'(rsp_tdata[56]));
         end
      end
   end

   // plain grids: short count, exact count, stop part way through a row
   task automatic test_regular_grid();
      send_request(make_request(64, 64, 0, 0, 16, 16, 0, 0, 64, 0));
      send_request(make_request(64, 64, 0, 0, 16, 16, 0, 0, 16, 1));
      send_request(make_request(64, 64, 0, 0, 16, 16, 0, 0, 5, 0));
   endtask

   // tiles overhanging the right and bottom edges
   task automatic test_edge_clipping();
      send_request(make_request(100, 50, 0, 0, 40, 40, 0, 0, 64, 0));
      send_request(make_request(4096, 4096, 4000, 4000, 200, 200, 0, 0, 3, 1));
   endtask

   // row restart with and without subregion mode
   task automatic test_row_restart();
      send_request(make_request(200, 120, 30, 10, 32, 24, 4, 6, 64, 1));
      send_request(make_request(200, 120, 30, 10, 32, 24, 4, 6, 64, 0));
      send_request(make_request(120, 100, 100, 0, 8, 30, 2, 3, 64, 1));
   endtask

   // requests that yield only the empty word
   task automatic test_empty_requests();
      send_request(make_request(0, 64, 0, 0, 8, 8, 0, 0, 10, 0));
      // first column past the right edge on every row
      send_request(make_request(40, 4096, 50, 0, 8, 8, 2, 0, 64, 1));
      send_request(make_request(64, 64, 0, 0, 0, 8, 0, 0, 10, 0));
      send_request(make_request(64, 64, 0, 0, 8, 0, 0, 0, 10, 1));
      send_request(make_request(64, 64, 0, 0, 8, 8, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // frame count and texture size above their maxima, all-ones fields
   task automatic test_saturation();
      send_request(make_request(8191, 8191, 0, 0, 1, 1, 0, 0, 127, 0));
      send_request(make_request(8191, 8191, 0, 0, 4096, 4096, 0, 0, 127, 0));
      send_request(make_request(8191, 8191, 4095, 4095, 8191, 8191, 4095, 4095, 127, 1));
      send_request(make_request(4097, 4096, 4095, 4095, 1, 1, 0, 0, 64, 1));
   endtask

   // sender holds off until the block has emptied, then resumes
   task automatic test_drain_pause();
      send_request(make_request(256, 256, 3, 5, 20, 12, 1, 2, 40, 1));
      wait_for_drain();
      send_request(make_request(256, 256, 3, 5, 20, 12, 1, 2, 40, 0));
   endtask

   // mostly well-formed sheets with random geometry, the rest raw noise
   task automatic test_random_sheets(input int count);
      sheet_request_type r;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 80) begin
            if ($urandom_range(7) == 0) begin
               r.tex_width  = TEX_FIELD_W'(TEX_LIMIT);
               r.tex_height = TEX_FIELD_W'(TEX_LIMIT);
               r.tile_w     = TILE_FIELD_W'($urandom_range(1024, 1));
               r.tile_h     = TILE_FIELD_W'($urandom_range(1024, 1));
            end else begin
               r.tex_width  = TEX_FIELD_W'($urandom_range(512, 16));
               r.tex_height = TEX_FIELD_W'($urandom_range(512, 16));
               r.tile_w     = TILE_FIELD_W'($urandom_range(128, 1));
               r.tile_h     = TILE_FIELD_W'($urandom_range(128, 1));
            end
            r.origin_x       = ORG_FIELD_W'($urandom_range(63));
            r.origin_y       = ORG_FIELD_W'($urandom_range(63));
            r.pad_x          = PAD_FIELD_W'($urandom_range(8));
            r.pad_y          = PAD_FIELD_W'($urandom_range(8));
            r.frames_wanted  = WANT_FIELD_W'($urandom_range(FRAME_LIMIT, 1));
            r.subregion_mode = 1'($urandom_range(1));
         end else begin
            r.tex_width      = TEX_FIELD_W'($urandom);
            r.tex_height     = TEX_FIELD_W'($urandom);
            r.origin_x       = ORG_FIELD_W'($urandom);
            r.origin_y       = ORG_FIELD_W'($urandom);
            r.tile_w         = TILE_FIELD_W'($urandom);
            r.tile_h         = TILE_FIELD_W'($urandom);
            r.pad_x          = PAD_FIELD_W'($urandom);
            r.pad_y          = PAD_FIELD_W'($urandom);
            r.frames_wanted  = WANT_FIELD_W'($urandom);
            r.subregion_mode = 1'($urandom);
         end
         send_request(r);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 32;
      recv_idle_pct = 64;
      test_regular_grid();
      test_edge_clipping();
      test_row_restart();
      test_empty_requests();
      test_saturation();
      test_drain_pause();
      test_random_sheets(30);
      wait_for_drain();

      // roles swapped
      send_idle_pct = 64;
      recv_idle_pct = 32;
      test_random_sheets(30);
      wait_for_drain();

      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_sheets(30);
      wait_for_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sprite_sheet_frame_slicer.f @@
rtl/ssfs_pkg.sv
rtl/ssfs_step_unit.sv
rtl/sprite_sheet_frame_slicer.sv
dv/tb_sprite_sheet_frame_slicer.sv
